// File: src/cfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_NEXT = 3'd1,
    OP_INC  = 3'd2,
    OP_DEC  = 3'd3,
    OP_TICK = 3'd4
  } opcode_t;

  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [6:0] MONTH_MIN  = 7'd1;
  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] DAY_MIN    = 7'd1;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [6:0] SECOND_MAX = 7'd59;
  localparam logic [6:0] ZERO_MIN   = 7'd0;

  localparam logic [15:0] BLINK_HALF_RESET = 16'd500;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_item_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] selected_field;
    logic       blank_selected;
  } out_item_t;

  // Month length; February is 29 days when the year is a multiple of four.
  function automatic logic [6:0] month_days(input logic [6:0] yr, input logic [6:0] mo);
    logic [6:0] len;
    len = 7'd31;
    if (mo == 7'd4 || mo == 7'd6 || mo == 7'd9 || mo == 7'd11) begin
      len = 7'd30;
    end else if (mo == 7'd2) begin
      len = (yr[1:0] == 2'b00) ? 7'd29 : 7'd28;
    end
    return len;
  endfunction

  // Above the max goes to the min, below the min goes to the max.
  function automatic logic [6:0] wrap_field(input logic signed [8:0] v,
                                            input logic [6:0] lo,
                                            input logic [6:0] hi);
    logic [6:0] res;
    res = v[6:0];
    if (v > $signed({2'b00, hi})) begin
      res = lo;
    end else if (v < $signed({2'b00, lo})) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/calendar_field_editor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Calendar field editor: six date/time fields, an edit selection and a blink flag.
// Input channel (in_valid/in_ready/in_data) carries one operation per item:
// load, next field, increment, decrement or tick. Every item yields exactly one
// result item on the output channel (out_valid/out_ready/out_data) showing the
// full state after that operation.
// The state and the result register update at the edge where the item is
// accepted, and out_valid is high from the next cycle.
// Throughput is one item per cycle while out_ready is high; the whole update is
// one pass of compare-and-wrap logic between the state and result registers.
// When the receiver stalls, the result register holds and in_ready drops until
// the result is taken; an item is accepted in the same cycle the held result
// leaves.
// cfg_wr_en/cfg_wr_data write the blink half period (ticks between toggles).
// Reset (rst_n low, synchronous) clears all fields, the selection, the blink
// flag and the divider, sets the half period to 500 and empties the result
// register.
module calendar_field_editor_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  cfe_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output cfe_pkg::out_item_t   out_data,
  input  wire                  cfg_wr_en,
  input  wire [15:0]           cfg_wr_data
);
  import cfe_pkg::*;

  logic [15:0] half_r;
  logic [6:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic        blink_r, blink_nxt;
  logic [15:0] div_r, div_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  logic              accept;
  logic signed [8:0] delta;
  logic [6:0]        w_year, w_month, w_day, w_hour, w_minute, w_second;
  logic [16:0]       div_inc;

  function automatic logic signed [8:0] edited(input logic [6:0] f, input logic hit,
                                                input logic signed [8:0] d);
    return $signed({2'b00, f}) + (hit ? d : 9'sd0);
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign div_inc  = {1'b0, div_r} + 17'd1;

  always_comb begin
    delta = (in_data.opcode == OP_DEC) ? -9'sd1 : 9'sd1;
    w_year   = wrap_field(edited(year_r, sel_r == FLD_YEAR, delta), ZERO_MIN, YEAR_MAX);
    w_month  = wrap_field(edited({3'b000, month_r}, sel_r == FLD_MONTH, delta),
                          MONTH_MIN, MONTH_MAX);
    // day bound follows the already wrapped year and month
    w_day    = wrap_field(edited({2'b00, day_r}, sel_r == FLD_DAY, delta),
                          DAY_MIN, month_days(w_year, w_month));
    w_hour   = wrap_field(edited({2'b00, hour_r}, sel_r == FLD_HOUR, delta),
                          ZERO_MIN, HOUR_MAX);
    w_minute = wrap_field(edited({1'b0, minute_r}, sel_r == FLD_MINUTE, delta),
                          ZERO_MIN, MINUTE_MAX);
    w_second = wrap_field(edited({1'b0, second_r}, sel_r == FLD_SECOND, delta),
                          ZERO_MIN, SECOND_MAX);

    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    sel_nxt    = sel_r;
    blink_nxt  = blink_r;
    div_nxt    = div_r;

    unique case (in_data.opcode)
      OP_LOAD: begin
        year_nxt   = in_data.load_year;
        month_nxt  = in_data.load_month;
        day_nxt    = in_data.load_day;
        hour_nxt   = in_data.load_hour;
        minute_nxt = in_data.load_minute;
        second_nxt = in_data.load_second;
        sel_nxt    = FLD_YEAR;
      end
      OP_NEXT: begin
        sel_nxt = (sel_r == FLD_SECOND) ? FLD_YEAR : sel_r + 3'd1;
      end
      OP_INC, OP_DEC: begin
        year_nxt   = w_year;
        month_nxt  = w_month[3:0];
        day_nxt    = w_day[4:0];
        hour_nxt   = w_hour[4:0];
        minute_nxt = w_minute[5:0];
        second_nxt = w_second[5:0];
      end
      OP_TICK: begin
        if (div_inc >= {1'b0, half_r}) begin
          div_nxt   = '0;
          blink_nxt = !blink_r;
        end else begin
          div_nxt = div_inc[15:0];
        end
      end
      default: begin
        // unused opcodes leave the state alone
      end
    endcase

    out_data_nxt.year           = year_nxt;
    out_data_nxt.month          = month_nxt;
    out_data_nxt.day            = day_nxt;
    out_data_nxt.hour           = hour_nxt;
    out_data_nxt.minute         = minute_nxt;
    out_data_nxt.second         = second_nxt;
    out_data_nxt.selected_field = sel_nxt;
    out_data_nxt.blank_selected = blink_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= BLINK_HALF_RESET;
      year_r      <= '0;
      month_r     <= '0;
      day_r       <= '0;
      hour_r      <= '0;
      minute_r    <= '0;
      second_r    <= '0;
      sel_r       <= FLD_YEAR;
      blink_r     <= 1'b0;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        half_r <= cfg_wr_data;
      end
      if (accept) begin
        year_r      <= year_nxt;
        month_r     <= month_nxt;
        day_r       <= day_nxt;
        hour_r      <= hour_nxt;
        minute_r    <= minute_nxt;
        second_r    <= second_nxt;
        sel_r       <= sel_nxt;
        blink_r     <= blink_nxt;
        div_r       <= div_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_calendar_field_editor_core.sv
`timescale 1ns / 1ps

module tb_calendar_field_editor_core;
  import cfe_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int RANDOM_PHASES = 6;
  localparam int MAX_PRINTS = 40;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // predictor state
  logic [6:0]  cal_fld [6];
  logic [2:0]  cur_sel;
  logic        blink_on;
  logic [15:0] tick_cnt;
  logic [15:0] half_period;

  out_item_t   display_q [$];
  out_item_t   want;
  int          err_count = 0;
  int          quiet = 0;

  // receiver stall pattern
  logic [31:0] cyc = '0;
  int          pat_mode = 0;
  int          pat_left = 0;
  int          stall_left = 0;

  calendar_field_editor_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    if (err_count < MAX_PRINTS) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    end
    err_count++;
  endtask

  task automatic reset_model();
    for (int i = 0; i < 6; i++) cal_fld[i] = '0;
    cur_sel     = '0;
    blink_on    = 1'b0;
    tick_cnt    = '0;
    half_period = BLINK_HALF_RESET;
  endtask

  function automatic int month_len(input int yr, input int mo);
    case (mo)
      4, 6, 9, 11: return 30;
      2:           return (yr % 4 == 0) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic int field_floor(input int idx);
    return (idx == FLD_MONTH || idx == FLD_DAY) ? 1 : 0;
  endfunction

  function automatic int field_ceiling(input int idx, input int yr, input int mo);
    case (idx)
      FLD_YEAR:   return int'(YEAR_MAX);
      FLD_MONTH:  return int'(MONTH_MAX);
      FLD_DAY:    return month_len(yr, mo);
      FLD_HOUR:   return int'(HOUR_MAX);
      FLD_MINUTE: return int'(MINUTE_MAX);
      default:    return int'(SECOND_MAX);
    endcase
  endfunction

  // Bump the selected field, then wrap all fields in order; the day limit
  // uses the already wrapped year and month.
  function automatic void apply_edit(input int delta);
    int v [6];
    int lo;
    int hi;
    for (int i = 0; i < 6; i++) v[i] = int'(cal_fld[i]);
    if (cur_sel < 6) v[cur_sel] += delta;
    for (int i = 0; i < 6; i++) begin
      lo = field_floor(i);
      hi = field_ceiling(i, v[FLD_YEAR], v[FLD_MONTH]);
      if (v[i] > hi) v[i] = lo;
      else if (v[i] < lo) v[i] = hi;
      cal_fld[i] = 7'(v[i]);
    end
  endfunction

  function automatic out_item_t next_display(input in_item_t item);
    out_item_t shown;
    int cnt;
    case (item.opcode)
      OP_LOAD: begin
        cal_fld[FLD_YEAR]   = item.load_year;
        cal_fld[FLD_MONTH]  = 7'(item.load_month);
        cal_fld[FLD_DAY]    = 7'(item.load_day);
        cal_fld[FLD_HOUR]   = 7'(item.load_hour);
        cal_fld[FLD_MINUTE] = 7'(item.load_minute);
        cal_fld[FLD_SECOND] = 7'(item.load_second);
        cur_sel = FLD_YEAR;
      end
      OP_NEXT: cur_sel = (cur_sel >= FLD_SECOND) ? FLD_YEAR : cur_sel + 3'd1;
      OP_INC:  apply_edit(1);
      OP_DEC:  apply_edit(-1);
      OP_TICK: begin
        cnt = tick_cnt + 1;
        if (cnt >= half_period) begin
          cnt = 0;
          blink_on = ~blink_on;
        end
        tick_cnt = cnt[15:0];
      end
      default: ;
    endcase
    shown.year           = cal_fld[FLD_YEAR];
    shown.month          = cal_fld[FLD_MONTH][3:0];
    shown.day            = cal_fld[FLD_DAY][4:0];
    shown.hour           = cal_fld[FLD_HOUR][4:0];
    shown.minute         = cal_fld[FLD_MINUTE][5:0];
    shown.second         = cal_fld[FLD_SECOND][5:0];
    shown.selected_field = cur_sel;
    shown.blank_selected = blink_on;
    return shown;
  endfunction

  // Item with random payload bits; the load fields matter only for a load.
  function automatic in_item_t noise_item(input logic [2:0] op);
    in_item_t item;
    item.opcode      = op;
    item.load_year   = 7'($urandom_range(0, 127));
    item.load_month  = 4'($urandom_range(0, 15));
    item.load_day    = 5'($urandom_range(0, 31));
    item.load_hour   = 5'($urandom_range(0, 31));
    item.load_minute = 6'($urandom_range(0, 63));
    item.load_second = 6'($urandom_range(0, 63));
    return item;
  endfunction

  function automatic in_item_t load_item(input int yr, input int mo, input int dy,
                                         input int hr, input int mi, input int se);
    in_item_t item;
    item.opcode      = OP_LOAD;
    item.load_year   = 7'(yr);
    item.load_month  = 4'(mo);
    item.load_day    = 5'(dy);
    item.load_hour   = 5'(hr);
    item.load_minute = 6'(mi);
    item.load_second = 6'(se);
    return item;
  endfunction

  function automatic in_item_t random_load();
    in_item_t item;
    item = noise_item(OP_LOAD);
    if ($urandom_range(0, 4) != 0) begin
      item.load_year   = 7'($urandom_range(0, 99));
      item.load_month  = 4'($urandom_range(1, 12));
      // lean toward month ends
      item.load_day    = 5'($urandom_range(0, 1) ? $urandom_range(27, 31)
                                                 : $urandom_range(1, 31));
      item.load_hour   = 5'($urandom_range(0, 23));
      item.load_minute = 6'($urandom_range(0, 59));
      item.load_second = 6'($urandom_range(0, 59));
    end
    return item;
  endfunction

  function automatic in_item_t random_item();
    int r;
    in_item_t item;
    r = $urandom_range(0, 99);
    item = noise_item(OP_TICK);
    if (r < 8) item = random_load();
    else if (r < 28) item.opcode = OP_NEXT;
    else if (r < 52) item.opcode = OP_INC;
    else if (r < 76) item.opcode = OP_DEC;
    else if (r < 96) item.opcode = OP_TICK;
    else if (r == 96) item.opcode = OP_RSVD_A;
    else if (r == 97) item.opcode = OP_RSVD_B;
    else item.opcode = OP_RSVD_C;
    return item;
  endfunction

  // Leaves in_valid high; the caller lowers it when a gap follows.
  task automatic send_item(input in_item_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    display_q.push_back(next_display(item));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (display_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_half(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    half_period = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (display_q.size() == 0) begin
        report_mismatch("unexpected result, year", 0, out_data.year);
      end else begin
        want = display_q.pop_front();
        if (out_data.year !== want.year) report_mismatch("year", want.year, out_data.year);
        if (out_data.month !== want.month) report_mismatch("month", want.month, out_data.month);
        if (out_data.day !== want.day) report_mismatch("day", want.day, out_data.day);
        if (out_data.hour !== want.hour) report_mismatch("hour", want.hour, out_data.hour);
        if (out_data.minute !== want.minute)
          report_mismatch("minute", want.minute, out_data.minute);
        if (out_data.second !== want.second)
          report_mismatch("second", want.second, out_data.second);
        if (out_data.selected_field !== want.selected_field)
          report_mismatch("selected_field", want.selected_field, out_data.selected_field);
        if (out_data.blank_selected !== want.blank_selected)
          report_mismatch("blank_selected", want.blank_selected, out_data.blank_selected);
      end
    end
  end

  always @(posedge clk) cyc <= cyc + 32'd1;

  // Receiver: switches among always ready, coin flip, one in four, and long stalls.
  always @(posedge clk) begin
    if (pat_left == 0) begin
      pat_mode <= $urandom_range(0, 3);
      pat_left <= $urandom_range(50, 400);
    end else begin
      pat_left <= pat_left - 1;
    end
    case (pat_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cyc[1:0] == 2'd0);
      default: begin
        if (stall_left != 0) begin
          out_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 20);
        end
      end
    endcase
  end

  initial begin : watchdog
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic test_reset_state();
    send_item(noise_item(OP_TICK));
  endtask

  task automatic test_year_wrap();
    send_item(load_item(99, 12, 31, 23, 59, 59));
    send_item(noise_item(OP_INC));
    send_item(noise_item(OP_DEC));
  endtask

  task automatic test_select_wrap();
    repeat (5) send_item(noise_item(OP_NEXT));
    send_item(noise_item(OP_INC));
    send_item(noise_item(OP_NEXT));
  endtask

  task automatic test_day_limit();
    // March 31 stepped back to February of a common year
    send_item(load_item(1, 3, 31, 0, 0, 0));
    send_item(noise_item(OP_NEXT));
    send_item(noise_item(OP_DEC));
    // leap day, then the year moves off the leap year
    send_item(load_item(4, 2, 29, 12, 30, 30));
    send_item(noise_item(OP_INC));
  endtask

  task automatic test_out_of_range_load();
    send_item(load_item(127, 0, 0, 31, 63, 63));
    send_item(noise_item(OP_INC));
  endtask

  task automatic test_unused_ops();
    send_item(noise_item(OP_RSVD_A));
    send_item(noise_item(OP_RSVD_B));
    send_item(noise_item(OP_RSVD_C));
  endtask

  task automatic test_blink_period();
    drain();
    write_half(16'd0);
    repeat (2) send_item(noise_item(OP_TICK));
    drain();
    write_half(16'hFFFF);
    send_item(noise_item(OP_TICK));
    drain();
    write_half(16'd1);
    repeat (2) send_item(noise_item(OP_TICK));
  endtask

  function automatic logic [15:0] phase_half(input int ph);
    case (ph)
      0:       return 16'd2;
      1:       return 16'd1;
      2:       return 16'd0;
      3:       return 16'd3;
      4:       return 16'hFFFF;
      default: return 16'($urandom_range(4, 40));
    endcase
  endfunction

  task automatic test_random_ops();
    int burst;
    int gap;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      write_half(phase_half(ph));
      burst = $urandom_range(1, 30);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_item());
        if (n == ITEMS_PER_PHASE - 1) begin
          // phase ends; next drain lowers valid
        end else if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 199) == 0) begin
          drain();
        end else begin
          burst--;
          if (burst == 0) begin
            burst = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
              in_valid <= 1'b0;
              repeat (gap) @(posedge clk);
            end
          end
        end
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_year_wrap();
    test_select_wrap();
    test_day_limit();
    test_out_of_range_load();
    test_unused_ops();
    test_blink_period();
    test_random_ops();
    drain();
    if (display_q.size() != 0) report_mismatch("results never arrived", 0, display_q.size());
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
